[hdl/sqlpmc_pkg.sv]
package sqlpmc_pkg;

   localparam int DATA_W     = 8;
   localparam int VALUE_W    = 32;
   localparam int IDX_W      = 15;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Configuration register indexes, taken from byte address bit 2.
   localparam logic REG_EXPECTED_TYPE = 1'b0;

   localparam logic [DATA_W-1:0] EXPECTED_TYPE_RESET = 8'd80;

   // The frame length counts its own four bytes.
   localparam logic [VALUE_W-1:0] LEN_SELF = 32'd4;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_DEST    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PARAM   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd3;

   // Final status codes.
   localparam logic [STATUS_W-1:0] ST_OK             = 4'd0;
   localparam logic [STATUS_W-1:0] ST_WRONG_TYPE     = 4'd1;
   localparam logic [STATUS_W-1:0] ST_DEST_UNTERM    = 4'd2;
   localparam logic [STATUS_W-1:0] ST_NO_QUERY       = 4'd3;
   localparam logic [STATUS_W-1:0] ST_QUERY_UNTERM   = 4'd4;
   localparam logic [STATUS_W-1:0] ST_NO_COUNT       = 4'd5;
   localparam logic [STATUS_W-1:0] ST_NEG_COUNT      = 4'd6;
   localparam logic [STATUS_W-1:0] ST_EXTRA_BYTES    = 4'd7;
   localparam logic [STATUS_W-1:0] ST_MISSING_PARAMS = 4'd8;

endpackage

[hdl/sqlpmc_if.sv]
interface sqlpmc_req_if;
   import sqlpmc_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface sqlpmc_rsp_if;
   import sqlpmc_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [VALUE_W-1:0]  value;
   logic [IDX_W-1:0]    param_index;
   logic                verdict;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output kind, output value, output param_index,
                   output verdict, output status, input ready);
   modport sink (input valid, input kind, input value, input param_index,
                 input verdict, input status, output ready);
endinterface

[hdl/sql_parse_message_checker.sv]
// Streaming checker for a Parse message of a database wire protocol. Bytes
// of the framed stream enter on the request channel, one item per byte: a
// type byte, a big-endian 32-bit length that counts itself, then the body
// (a null-terminated destination name, a null-terminated query, a signed
// 16-bit parameter count and that many 32-bit type identifiers). For each
// destination or query character, and for each assembled type identifier,
// one item leaves on the response channel; the final status of a frame is
// given once, on its last byte or at the first error, and after an error the
// rest of the frame is dropped. The block takes one byte per clock cycle
// while the skid register is empty. Each byte is decoded combinationally
// against the parser state; its result, if any, goes to the response
// register, or to the one-item skid register if the response waits untaken,
// so bytes keep flowing; the request ready drops only when both hold an item.
// The expected type byte (reset 80) is written over the APB-style port at
// byte address 0; the user must write it only while idle (not enforced).
module sql_parse_message_checker (
   input  logic                                clock,
   input  logic                                reset,
   sqlpmc_req_if.sink                          req_chan,
   sqlpmc_rsp_if.source                        rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sqlpmc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sqlpmc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sqlpmc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import sqlpmc_pkg::*;

   typedef enum logic [2:0] {
      PH_TYPE   = 3'd0,
      PH_LEN    = 3'd1,
      PH_DEST   = 3'd2,
      PH_QUERY  = 3'd3,
      PH_COUNT  = 3'd4,
      PH_PARAMS = 3'd5,
      PH_DROP   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [VALUE_W-1:0]  value;
      logic [IDX_W-1:0]    param_index;
      logic                verdict;
      logic [STATUS_W-1:0] status;
   } rsp_item_type;

   // Parser state.
   phase_type          phase_ff, phase_in;
   logic [VALUE_W-1:0] bytes_left_ff, bytes_left_in;
   logic [1:0]         field_pos_ff, field_pos_in;
   logic [VALUE_W-1:0] assembly_ff, assembly_in;
   logic [IDX_W-1:0]   params_left_ff, params_left_in;
   logic [IDX_W-1:0]   param_pos_ff, param_pos_in;
   logic               error_seen_ff, error_seen_in;
   logic [DATA_W-1:0]  expected_type_ff;

   // Response register and skid register.
   logic               out_valid_ff, out_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   rsp_item_type       out_item_ff;
   rsp_item_type       skid_item_ff;

   // Decode of the current byte.
   phase_type           eff_phase;
   logic [DATA_W-1:0]   byte_v;
   logic [VALUE_W-1:0]  shifted;
   logic [1:0]          pos_inc;
   logic [15:0]         count;
   logic [VALUE_W-1:0]  need;
   logic                emit;
   logic                fin;
   logic [STATUS_W-1:0] fin_status;
   rsp_item_type        res;
   logic                accept;
   logic                take;
   logic                push;
   logic                load_out_res;
   logic                load_out_skid;
   logic                load_skid;
   logic                csr_write;

   assign byte_v  = req_chan.data_byte;
   assign shifted = {assembly_ff[VALUE_W-DATA_W-1:0], byte_v};
   assign pos_inc = field_pos_ff + 2'd1;
   assign count   = {assembly_ff[DATA_W-1:0], byte_v};
   // Four bytes per parameter; only the magnitude bits matter once the sign is clear.
   assign need    = {{(VALUE_W-17){1'b0}}, count[14:0], 2'b00};

   always_comb begin
      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      field_pos_in   = field_pos_ff;
      assembly_in    = assembly_ff;
      params_left_in = params_left_ff;
      param_pos_in   = param_pos_ff;
      error_seen_in  = error_seen_ff;
      emit           = 1'b0;
      fin            = 1'b0;
      fin_status     = ST_OK;
      res            = '0;
      eff_phase      = phase_ff;

      // Body phases consume one byte of the frame length. A body phase with
      // nothing left falls back to waiting for a type byte.
      if (phase_ff != PH_TYPE && phase_ff != PH_LEN) begin
         if (bytes_left_ff == '0) begin
            eff_phase = PH_TYPE;
         end else begin
            bytes_left_in = bytes_left_ff - 32'd1;
         end
      end

      unique case (eff_phase)
         PH_LEN: begin
            assembly_in  = shifted;
            field_pos_in = pos_inc;
            if (pos_inc == 2'd0) begin
               bytes_left_in = (shifted < LEN_SELF) ? '0 : shifted - LEN_SELF;
               assembly_in   = '0;
               if (error_seen_ff) begin
                  phase_in = (bytes_left_in != '0) ? PH_DROP : PH_TYPE;
               end else if (bytes_left_in == '0) begin
                  fin        = 1'b1;
                  fin_status = ST_DEST_UNTERM;
                  res.kind   = KIND_VERDICT;
               end else begin
                  phase_in = PH_DEST;
               end
            end
         end
         PH_DEST: begin
            if (byte_v == '0) begin
               if (bytes_left_in == '0) begin
                  fin        = 1'b1;
                  fin_status = ST_NO_QUERY;
                  res.kind   = KIND_VERDICT;
               end else begin
                  phase_in = PH_QUERY;
               end
            end else begin
               res.kind  = KIND_DEST;
               res.value = {{(VALUE_W-DATA_W){1'b0}}, byte_v};
               if (bytes_left_in == '0) begin
                  fin        = 1'b1;
                  fin_status = ST_DEST_UNTERM;
               end else begin
                  emit = 1'b1;
               end
            end
         end
         PH_QUERY: begin
            if (byte_v == '0) begin
               if (bytes_left_in == '0) begin
                  fin        = 1'b1;
                  fin_status = ST_NO_COUNT;
                  res.kind   = KIND_VERDICT;
               end else begin
                  phase_in     = PH_COUNT;
                  field_pos_in = 2'd0;
               end
            end else begin
               res.kind  = KIND_QUERY;
               res.value = {{(VALUE_W-DATA_W){1'b0}}, byte_v};
               if (bytes_left_in == '0) begin
                  fin        = 1'b1;
                  fin_status = ST_QUERY_UNTERM;
               end else begin
                  emit = 1'b1;
               end
            end
         end
         PH_COUNT: begin
            res.kind = KIND_VERDICT;
            if (field_pos_ff == 2'd0) begin
               if (bytes_left_in == '0) begin
                  fin        = 1'b1;
                  fin_status = ST_NO_COUNT;
               end else begin
                  assembly_in  = {{(VALUE_W-DATA_W){1'b0}}, byte_v};
                  field_pos_in = 2'd1;
               end
            end else begin
               assembly_in  = '0;
               field_pos_in = 2'd0;
               priority if (count[15]) begin
                  fin        = 1'b1;
                  fin_status = ST_NEG_COUNT;
               end else if (bytes_left_in > need) begin
                  fin        = 1'b1;
                  fin_status = ST_EXTRA_BYTES;
               end else if (bytes_left_in < need) begin
                  fin        = 1'b1;
                  fin_status = ST_MISSING_PARAMS;
               end else if (count == '0) begin
                  fin        = 1'b1;
                  fin_status = ST_OK;
               end else begin
                  params_left_in = count[IDX_W-1:0];
                  param_pos_in   = '0;
                  phase_in       = PH_PARAMS;
               end
            end
         end
         PH_PARAMS: begin
            assembly_in  = shifted;
            field_pos_in = pos_inc;
            if (pos_inc == 2'd0) begin
               res.kind        = KIND_PARAM;
               res.value       = shifted;
               res.param_index = param_pos_ff;
               assembly_in     = '0;
               param_pos_in    = param_pos_ff + 15'd1;
               if (params_left_ff != '0) begin
                  params_left_in = params_left_ff - 15'd1;
               end
               if (params_left_in == '0 || bytes_left_in == '0) begin
                  fin        = 1'b1;
                  fin_status = ST_OK;
               end else begin
                  emit = 1'b1;
               end
            end
         end
         PH_DROP: begin
            if (bytes_left_in == '0) begin
               phase_in = PH_TYPE;
            end
         end
         default: begin
            // Type byte, also taken for any phase code that means nothing.
            phase_in       = PH_LEN;
            field_pos_in   = 2'd0;
            assembly_in    = '0;
            bytes_left_in  = '0;
            params_left_in = '0;
            param_pos_in   = '0;
            if (byte_v != expected_type_ff) begin
               error_seen_in = 1'b1;
               emit          = 1'b1;
               res.kind      = KIND_VERDICT;
               res.verdict   = 1'b1;
               res.status    = ST_WRONG_TYPE;
            end else begin
               error_seen_in = 1'b0;
            end
         end
      endcase

      // A final status closes the frame; what remains of it is dropped.
      if (fin) begin
         res.verdict   = 1'b1;
         res.status    = fin_status;
         error_seen_in = (fin_status != ST_OK);
         field_pos_in  = 2'd0;
         phase_in      = (bytes_left_in != '0) ? PH_DROP : PH_TYPE;
      end
   end

   // Handshakes. The skid register lets a byte in while the response waits.
   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && !skid_valid_ff;
   assign take           = out_valid_ff && rsp_chan.ready;
   assign push           = accept && (emit || fin);

   assign load_out_skid = skid_valid_ff && take;
   assign load_out_res  = push && !skid_valid_ff && (!out_valid_ff || take);
   assign load_skid     = push && !skid_valid_ff && out_valid_ff && !take;
   assign out_valid_in  = skid_valid_ff || push || (out_valid_ff && !take);
   assign skid_valid_in = skid_valid_ff ? !take : load_skid;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_EXPECTED_TYPE) ?
                       {{(CSR_DATA_W-DATA_W){1'b0}}, expected_type_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_TYPE;
         bytes_left_ff    <= '0;
         field_pos_ff     <= '0;
         assembly_ff      <= '0;
         params_left_ff   <= '0;
         param_pos_ff     <= '0;
         error_seen_ff    <= 1'b0;
         expected_type_ff <= EXPECTED_TYPE_RESET;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff       <= phase_in;
            bytes_left_ff  <= bytes_left_in;
            field_pos_ff   <= field_pos_in;
            assembly_ff    <= assembly_in;
            params_left_ff <= params_left_in;
            param_pos_ff   <= param_pos_in;
            error_seen_ff  <= error_seen_in;
         end
         if (csr_write && csr_paddr[2] == REG_EXPECTED_TYPE) begin
            expected_type_ff <= csr_pwdata[DATA_W-1:0];
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out_skid) begin
         out_item_ff <= skid_item_ff;
      end else if (load_out_res) begin
         out_item_ff <= res;
      end
      if (load_skid) begin
         skid_item_ff <= res;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.kind        = out_item_ff.kind;
   assign rsp_chan.value       = out_item_ff.value;
   assign rsp_chan.param_index = out_item_ff.param_index;
   assign rsp_chan.verdict     = out_item_ff.verdict;
   assign rsp_chan.status      = out_item_ff.status;

`ifndef SYNTHESIS
   // The skid register only fills behind a waiting response.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds an item while the response register is empty");

   // A result without a verdict never carries a status.
   a_status_needs_verdict: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_item_ff.verdict) |-> (out_item_ff.status == ST_OK))
      else $error("status set on a result without a verdict");

   // A verdict-only result carries the verdict and no value.
   a_verdict_only: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.kind == KIND_VERDICT) |->
      (out_item_ff.verdict && out_item_ff.value == '0))
      else $error("verdict-only result without verdict or with a value");

   // Body phases are only entered with frame bytes still to come.
   a_body_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DEST || phase_ff == PH_QUERY || phase_ff == PH_COUNT ||
       phase_ff == PH_PARAMS || phase_ff == PH_DROP) |-> (bytes_left_ff != '0))
      else $error("body phase with no frame bytes left");

   // A byte that produces a result is never taken while the skid is full.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("result produced while both response registers are full");
`endif

endmodule
